### design/rfsbs_pkg.sv
// Package for the RF sweep bin stepper: shared types, band constants and
// the fixed-point reciprocal used for the synthesizer word.
// No dependencies; imported by every module of the block.
package rfsbs_pkg;

  // Field widths.
  localparam int unsigned BIN_COUNT_DEF = 128;
  localparam int unsigned BIN_IDX_W     = 7;
  localparam int unsigned RSSI_W        = 8;
  localparam int unsigned LEVEL_W       = 8;
  localparam int unsigned HZ_W          = 30;
  localparam int unsigned POS_W         = 29;
  localparam int unsigned WORD_W        = 24;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Tuning bands in hertz.
  localparam int unsigned BAND0_LO    = 300000000;
  localparam int unsigned BAND1_LO    = 387000000;
  localparam int unsigned BAND2_LO    = 779000000;
  localparam int unsigned BAND0_WIDTH = 48000000;
  localparam int unsigned BAND1_WIDTH = 77000000;
  localparam int unsigned BAND2_WIDTH = 149000000;
  localparam int unsigned TOTAL_WIDTH = BAND0_WIDTH + BAND1_WIDTH + BAND2_WIDTH;

  // Position thresholds between bands within the concatenated span.
  localparam logic [POS_W-1:0] SPLIT_MID  = POS_W'(BAND0_WIDTH);
  localparam logic [POS_W-1:0] SPLIT_HIGH = POS_W'(BAND0_WIDTH + BAND1_WIDTH);

  // The word is floor(hz * 2^16 / 26e6) = floor(hz * 2^9 / 203125). It is formed as
  // floor(hz * RECIP_M / 2^48) with RECIP_M = ceil(2^57 / 203125), which is exact
  // for every frequency below 2^30 Hz.
  localparam int unsigned RECIP_SHIFT  = 48;
  localparam int unsigned RECIP_M_W    = 40;
  localparam int unsigned RECIP_HALF_W = RECIP_M_W / 2;
  localparam logic [63:0] RECIP_FULL   = ((64'd1 << 57) + 64'd203124) / 64'd203125;
  localparam logic [RECIP_M_W-1:0] RECIP_M = RECIP_FULL[RECIP_M_W-1:0];

  // Level conversion.
  localparam int LEVEL_OFFSET = 74;
  localparam int LEVEL_FLOOR  = -127;

  typedef enum logic [1:0] {
    BAND_LOW  = 2'd0,
    BAND_MID  = 2'd1,
    BAND_HIGH = 2'd2,
    BAND_NONE = 2'd3
  } band_e;

  typedef struct packed {
    logic signed [RSSI_W-1:0] rssi_first;
    logic signed [RSSI_W-1:0] rssi_second;
  } in_t;

  typedef struct packed {
    logic [BIN_IDX_W-1:0]      bin_index;
    logic [1:0]                band_number;
    logic                      switch_zero;
    logic                      switch_one;
    logic                      band_changed;
    logic [HZ_W-1:0]           centre_hz;
    logic [WORD_W-1:0]         freq_word;
    logic signed [LEVEL_W-1:0] level_dbm;
  } out_t;

  // One classified step as it travels from the front to the back.
  typedef struct packed {
    logic [BIN_IDX_W-1:0]      bin_index;
    band_e                     band;
    logic                      band_changed;
    logic [POS_W-1:0]          pos;
    logic signed [LEVEL_W-1:0] level_dbm;
  } entry_t;

  // Antenna switch levels per band.
  function automatic logic band_sw0(band_e band);
    logic sw;
    unique case (band)
      BAND_LOW:  sw = 1'b0;
      BAND_MID:  sw = 1'b1;
      BAND_HIGH: sw = 1'b1;
      default:   sw = 1'b0;
    endcase
    return sw;
  endfunction

  function automatic logic band_sw1(band_e band);
    logic sw;
    unique case (band)
      BAND_LOW:  sw = 1'b1;
      BAND_MID:  sw = 1'b1;
      BAND_HIGH: sw = 1'b0;
      default:   sw = 1'b0;
    endcase
    return sw;
  endfunction

endpackage

### design/rf_sweep_bin_stepper_top.sv
// Top level of the RF sweep bin stepper.
// A result is registered in the queue and then in the back-end pipeline
// (centre frequency, partial products, word and output register).
// Throughput: one step per cycle unless stalled; the two-entry queue lets input and output stall apart.
// Reset: asynchronous, active low; the cursor returns to bin zero and the last
// band to none, so the first result after reset flags a band change.
module rf_sweep_bin_stepper_top #(
  parameter int unsigned BIN_COUNT = rfsbs_pkg::BIN_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rfsbs_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rfsbs_pkg::out_t  out_data_o
);
  import rfsbs_pkg::*;

  logic   push;
  logic   pop;
  logic   queue_valid;
  logic   queue_full;
  entry_t push_entry;
  entry_t queue_head;

  assign in_stall_o = queue_full;

  // Front end: level, cursor and band classification.
  rfsbs_front #(
    .BIN_COUNT (BIN_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // Decoupling queue.
  rfsbs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .valid_o     (queue_valid),
    .full_o      (queue_full),
    .head_o      (queue_head)
  );

  // Back end: frequency, synthesizer word and output register.
  rfsbs_back #(
    .BIN_COUNT (BIN_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_valid_i (queue_valid),
    .queue_head_i  (queue_head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

### design/rfsbs_front.sv
// Front end of the sweep bin stepper: accepts RSSI pairs, converts the level,
// tracks the bin cursor and its span position, and classifies the band.
// Depends on rfsbs_pkg.
module rfsbs_front #(
  parameter int unsigned BIN_COUNT = rfsbs_pkg::BIN_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  rfsbs_pkg::in_t     in_data_i,
  input  logic               queue_full_i,
  output logic               push_o,
  output rfsbs_pkg::entry_t  entry_o
);
  import rfsbs_pkg::*;

  localparam int unsigned CW     = $clog2(BIN_COUNT);
  localparam int unsigned STEP_Q = TOTAL_WIDTH / BIN_COUNT;
  localparam int unsigned STEP_R = TOTAL_WIDTH % BIN_COUNT;
  localparam logic [CW:0]   COUNT_W  = (CW+1)'(BIN_COUNT);
  localparam logic [CW:0]   STEP_R_W = (CW+1)'(STEP_R);
  localparam logic [CW-1:0] LAST_BIN = CW'(BIN_COUNT - 1);
  localparam logic signed [LEVEL_W:0] OFFSET_S = (LEVEL_W+1)'(LEVEL_OFFSET);
  localparam logic signed [LEVEL_W:0] FLOOR_S  = (LEVEL_W+1)'(LEVEL_FLOOR);

  logic [CW-1:0]    cursor_q, cursor_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [CW-1:0]    rem_q, rem_d;
  band_e            last_band_q;

  logic [CW:0]      rem_sum;
  logic             rem_wrap;
  band_e            band;

  logic signed [RSSI_W-1:0]  raw;
  logic signed [RSSI_W:0]    raw_adj;
  logic signed [RSSI_W:0]    half;
  logic signed [LEVEL_W:0]   lvl;
  logic signed [LEVEL_W:0]   lvl_clamped;

  assign push_o = in_valid_i && !queue_full_i;

  // The span position is kept as quotient and remainder of TOTAL_WIDTH * cursor
  // over BIN_COUNT, so that each step adds a constant and corrects once.
  always_comb begin
    rem_sum  = {1'b0, rem_q} + STEP_R_W;
    rem_wrap = (rem_sum >= COUNT_W);
    if (cursor_q == LAST_BIN) begin
      cursor_d = '0;
      pos_d    = '0;
      rem_d    = '0;
    end else begin
      cursor_d = cursor_q + CW'(1);
      pos_d    = pos_q + POS_W'(STEP_Q) + POS_W'(rem_wrap);
      rem_d    = rem_wrap ? CW'(rem_sum - COUNT_W) : CW'(rem_sum);
    end
  end

  // Band classification of the current position.
  always_comb begin
    if (pos_q < SPLIT_MID) begin
      band = BAND_LOW;
    end else if (pos_q < SPLIT_HIGH) begin
      band = BAND_MID;
    end else begin
      band = BAND_HIGH;
    end
  end

  // Level: larger sample halved towards zero, offset, clamped from below.
  always_comb begin
    raw         = (in_data_i.rssi_first > in_data_i.rssi_second) ?
                  in_data_i.rssi_first : in_data_i.rssi_second;
    raw_adj     = $signed({raw[RSSI_W-1], raw}) + $signed({{RSSI_W{1'b0}}, raw[RSSI_W-1]});
    half        = raw_adj >>> 1;
    lvl         = half - OFFSET_S;
    lvl_clamped = (lvl < FLOOR_S) ? FLOOR_S : lvl;
  end

  always_comb begin
    entry_o.bin_index    = BIN_IDX_W'(cursor_q);
    entry_o.band         = band;
    entry_o.band_changed = (band != last_band_q);
    entry_o.pos          = pos_q;
    entry_o.level_dbm    = lvl_clamped[LEVEL_W-1:0];
  end

  // Cursor state advances on every transfer into the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      pos_q       <= '0;
      rem_q       <= '0;
      last_band_q <= BAND_NONE;
    end else if (push_o) begin
      cursor_q    <= cursor_d;
      pos_q       <= pos_d;
      rem_q       <= rem_d;
      last_band_q <= band;
    end
  end

endmodule

### design/rfsbs_queue.sv
// Two-entry queue between the front and the back of the sweep bin stepper.
// Depends on rfsbs_pkg for the entry type and depth.
module rfsbs_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rfsbs_pkg::entry_t  push_data_i,
  input  logic               pop_i,
  output logic               valid_o,
  output logic               full_o,
  output rfsbs_pkg::entry_t  head_o
);
  import rfsbs_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [CNT_W-1:0]   count_q;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

### design/rfsbs_back.sv
// Back end of the sweep bin stepper: forms the bin centre frequency and the
// synthesizer word in a three-stage pipeline ending in the output register.
// Depends on rfsbs_pkg.
module rfsbs_back #(
  parameter int unsigned BIN_COUNT = rfsbs_pkg::BIN_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               queue_valid_i,
  input  rfsbs_pkg::entry_t  queue_head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rfsbs_pkg::out_t    out_data_o
);
  import rfsbs_pkg::*;

  // Per-band base: band low edge, minus the span below it, plus the band width over twice the bin count.
  localparam logic [HZ_W-1:0] BASE_LOW  =
    HZ_W'(BAND0_LO + BAND0_WIDTH / (2 * BIN_COUNT));
  localparam logic [HZ_W-1:0] BASE_MID  =
    HZ_W'(BAND1_LO - BAND0_WIDTH + BAND1_WIDTH / (2 * BIN_COUNT));
  localparam logic [HZ_W-1:0] BASE_HIGH =
    HZ_W'(BAND2_LO - BAND0_WIDTH - BAND1_WIDTH + BAND2_WIDTH / (2 * BIN_COUNT));
  localparam int unsigned PROD_W = HZ_W + RECIP_HALF_W;
  localparam int unsigned SUM_W  = RECIP_SHIFT + WORD_W;

  logic                    s1_valid_q;
  entry_t                  s1_entry_q;
  logic [HZ_W-1:0]         s1_hz_q;
  logic                    s2_valid_q;
  entry_t                  s2_entry_q;
  logic [HZ_W-1:0]         s2_hz_q;
  logic [PROD_W-1:0]       s2_plo_q;
  logic [PROD_W-1:0]       s2_phi_q;
  logic                    out_valid_q;
  out_t                    out_q;

  logic                    en_out, en_s2, en_s1;
  logic [HZ_W-1:0]         base;
  logic [HZ_W-1:0]         hz_d;
  logic [PROD_W-1:0]       plo_d, phi_d;
  logic [SUM_W-1:0]        prod_sum;
  out_t                    out_d;

  // Each stage loads when it is empty or its contents move on.
  assign en_out = !out_valid_q || !out_stall_i;
  assign en_s2  = !s2_valid_q || en_out;
  assign en_s1  = !s1_valid_q || en_s2;
  assign pop_o  = queue_valid_i && en_s1;

  // Stage one: centre frequency.
  always_comb begin
    unique case (queue_head_i.band)
      BAND_LOW:  base = BASE_LOW;
      BAND_MID:  base = BASE_MID;
      BAND_HIGH: base = BASE_HIGH;
      default:   base = BASE_HIGH;
    endcase
    hz_d = HZ_W'(queue_head_i.pos) + base;
  end

  // Stage two: two partial products of the reciprocal multiplication.
  always_comb begin
    plo_d = PROD_W'(s1_hz_q) * PROD_W'(RECIP_M[RECIP_HALF_W-1:0]);
    phi_d = PROD_W'(s1_hz_q) * PROD_W'(RECIP_M[RECIP_M_W-1:RECIP_HALF_W]);
  end

  // Stage three: combine the partial products and assemble the result.
  always_comb begin
    prod_sum           = SUM_W'({s2_phi_q, {RECIP_HALF_W{1'b0}}}) + SUM_W'(s2_plo_q);
    out_d.bin_index    = s2_entry_q.bin_index;
    out_d.band_number  = s2_entry_q.band;
    out_d.switch_zero  = band_sw0(s2_entry_q.band);
    out_d.switch_one   = band_sw1(s2_entry_q.band);
    out_d.band_changed = s2_entry_q.band_changed;
    out_d.centre_hz    = s2_hz_q;
    out_d.freq_word    = prod_sum[RECIP_SHIFT +: WORD_W];
    out_d.level_dbm    = s2_entry_q.level_dbm;
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (en_s1) begin
      s1_entry_q <= queue_head_i;
      s1_hz_q    <= hz_d;
    end
    if (en_s2) begin
      s2_entry_q <= s1_entry_q;
      s2_hz_q    <= s1_hz_q;
      s2_plo_q   <= plo_d;
      s2_phi_q   <= phi_d;
    end
    if (en_out) begin
      out_q <= out_d;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_s1) begin
        s1_valid_q <= queue_valid_i;
      end
      if (en_s2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (en_out) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
